>>> rtl/core/cht_pkg.sv
// shared types and constants for the chained hash table
`default_nettype none
package cht_pkg;
	localparam int unsigned MaxBucketsDef = 64;
	localparam int unsigned PoolNodesDef = 256;
	localparam int unsigned NameBytesDef = 8;

	localparam int unsigned KeyW = 31;
	localparam int unsigned NameW = 64;
	localparam int unsigned YearW = 16;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW = 5;
	localparam int unsigned CfgW = 7;

	localparam logic [1:0] OpInsert = 2'd0;
	localparam logic [1:0] OpSearch = 2'd1;
	localparam logic [1:0] OpClear = 2'd2;

	localparam logic [1:0] StDone = 2'd0;
	localparam logic [1:0] StNotFound = 2'd1;
	localparam logic [1:0] StFull = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [KeyW-1:0] key;
		logic [NameW-1:0] name;
		logic [YearW-1:0] year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0] day;
	} req_t;
endpackage
`default_nettype wire

>>> rtl/core/cht_front.sv
// front end: request capture and a two-entry request queue
`default_nettype none
module cht_front (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input wire cht_pkg::req_t in_req,
	output logic q_valid,
	input wire q_pop,
	output cht_pkg::req_t q_req
);
	import cht_pkg::*;

	req_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_req;
	end
endmodule
`default_nettype wire

>>> rtl/core/cht_back.sv
// back end: hashing, bucket table, node pool and chain walk
`default_nettype none
module cht_back #(
	parameter int unsigned MAX_BUCKETS = cht_pkg::MaxBucketsDef,
	parameter int unsigned POOL_NODES = cht_pkg::PoolNodesDef,
	parameter int unsigned NAME_BYTES = cht_pkg::NameBytesDef
) (
	input wire clk,
	input wire arst_n,
	input wire [cht_pkg::CfgW-1:0] bucket_count,
	input wire q_valid,
	output logic q_pop,
	input wire cht_pkg::req_t q_req,
	output logic out_valid,
	input wire out_stall,
	output logic [1:0] status,
	output logic [cht_pkg::NameW-1:0] name_out,
	output logic [cht_pkg::YearW-1:0] year_out,
	output logic [cht_pkg::MonthW-1:0] month_out,
	output logic [cht_pkg::DayW-1:0] day_out
);
	import cht_pkg::*;

	localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int unsigned PW = $clog2(POOL_NODES);
	localparam int unsigned CW = PW + 1;
	localparam int unsigned NodeW = KeyW + NameW + YearW + MonthW + DayW;
	localparam logic [NameW-1:0] NameMask = (NAME_BYTES >= 8) ? {NameW{1'b1}}
		: NameW'((65'd1 << (8 * NAME_BYTES)) - 65'd1);
	localparam logic [CW-1:0] PoolCnt = CW'(POOL_NODES);
	localparam int unsigned BkW = (MAX_BUCKETS > 127) ? 13 : CfgW;
	localparam logic [BkW-1:0] MaxB = BkW'(MAX_BUCKETS);

	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_HEAD, S_RD, S_CMP, S_CLR, S_OUT
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [KeyW-1:0] rem_q;
	logic [4:0] bit_q;
	logic [BkW-1:0] div_q;
	logic [BW-1:0] bkt_q;
	logic [CW-1:0] used_q;
	logic [PW-1:0] at_q;
	logic [PW:0] steps_q;

	// bucket heads and tails with valid bits
	logic [MAX_BUCKETS-1:0] hvalid_q;
	logic [PW-1:0] head_mem [MAX_BUCKETS];
	logic [PW-1:0] tail_mem [MAX_BUCKETS];
	logic [PW-1:0] head_rd_q, tail_rd_q;
	logic hv_rd_q;

	logic [NodeW-1:0] node_mem [POOL_NODES];
	logic [PW:0] link_mem [POOL_NODES];
	logic [NodeW-1:0] node_rd_q;
	logic [PW:0] link_rd_q;

	logic node_we, link_we;
	logic [PW-1:0] link_wa;
	logic [PW-1:0] node_ra;
	logic node_re;

	logic [BkW-1:0] div_c;
	logic [KeyW:0] trial;
	logic [KeyW-1:0] rem_sh;

	always_comb begin
		div_c = {{(BkW-CfgW){1'b0}}, bucket_count};
		if (div_c == '0) div_c = BkW'(1);
		if (div_c > MaxB) div_c = MaxB;
	end

	// restoring remainder, one key bit per cycle
	assign rem_sh = {rem_q[KeyW-2:0], req_q.key[bit_q]};
	assign trial = {1'b0, rem_sh} - {{(KeyW+1-BkW){1'b0}}, div_q};

	assign q_pop = (state_q == S_IDLE) && q_valid;

	logic hit;
	assign hit = (node_rd_q[NodeW-1 -: KeyW] == req_q.key);

	assign node_we = (state_q == S_HEAD) && (req_q.op == OpInsert) && (used_q < PoolCnt);
	assign link_we = node_we && hv_rd_q;
	assign link_wa = tail_rd_q;
	assign node_re = (state_q == S_RD);
	assign node_ra = at_q;

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[used_q[PW-1:0]] <= {req_q.key, req_q.name & NameMask,
				req_q.year, req_q.month, req_q.day};
			link_mem[used_q[PW-1:0]] <= '0;
		end
		if (link_we) link_mem[link_wa] <= {1'b1, used_q[PW-1:0]};
		if (node_re) begin
			node_rd_q <= node_mem[node_ra];
			link_rd_q <= link_mem[node_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HASH && bit_q == 5'd0) begin
			head_rd_q <= head_mem[BW'(trial[KeyW] ? rem_sh : trial[KeyW-1:0])];
			tail_rd_q <= tail_mem[BW'(trial[KeyW] ? rem_sh : trial[KeyW-1:0])];
		end
		if (node_we) begin
			tail_mem[bkt_q] <= used_q[PW-1:0];
			if (!hv_rd_q) head_mem[bkt_q] <= used_q[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hvalid_q <= '0;
			used_q <= '0;
			out_valid <= 1'b0;
			hv_rd_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						req_q <= q_req;
						rem_q <= '0;
						bit_q <= 5'(KeyW - 1);
						div_q <= div_c;
						status <= StDone;
						name_out <= '0;
						year_out <= '0;
						month_out <= '0;
						day_out <= '0;
						unique case (q_req.op) inside
							OpInsert, OpSearch: state_q <= S_HASH;
							OpClear: state_q <= S_CLR;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_HASH: begin
					rem_q <= trial[KeyW] ? rem_sh : trial[KeyW-1:0];
					if (bit_q == 5'd0) begin
						bkt_q <= BW'(trial[KeyW] ? rem_sh : trial[KeyW-1:0]);
						hv_rd_q <= hvalid_q[BW'(trial[KeyW] ? rem_sh : trial[KeyW-1:0])];
						state_q <= S_HEAD;
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
				S_HEAD: begin
					if (req_q.op == OpInsert) begin
						if (used_q < PoolCnt) begin
							used_q <= used_q + CW'(1);
							hvalid_q[bkt_q] <= 1'b1;
						end else begin
							status <= StFull;
						end
						state_q <= S_OUT;
					end else if (hv_rd_q) begin
						at_q <= head_rd_q;
						steps_q <= '0;
						state_q <= S_RD;
					end else begin
						status <= StNotFound;
						state_q <= S_OUT;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (hit) begin
						name_out <= node_rd_q[NodeW-KeyW-1 -: NameW];
						year_out <= node_rd_q[MonthW+DayW +: YearW];
						month_out <= node_rd_q[DayW +: MonthW];
						day_out <= node_rd_q[DayW-1:0];
						state_q <= S_OUT;
					end else if (link_rd_q[PW] && steps_q < (PW+1)'(POOL_NODES - 1)) begin
						at_q <= link_rd_q[PW-1:0];
						steps_q <= steps_q + (PW+1)'(1);
						state_q <= S_RD;
					end else begin
						status <= StNotFound;
						state_q <= S_OUT;
					end
				end
				S_CLR: begin
					hvalid_q <= '0;
					used_q <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/chained_hash_table.sv
// chained hash table top level
// an insert, or a search on an empty bucket, goes from the hash straight to the result
// the key modulo bucket count is computed by restoring division, one remainder bit per cycle
// a search reads and then compares each node it walks; clear drops all buckets and nodes at once
// one request in the back end at a time, the next is taken once it is idle after the result is taken
// reset clears bucket valid bits and node count at once; bucket_count resets to 64
`default_nettype none
module chained_hash_table #(
	parameter int unsigned MAX_BUCKETS = cht_pkg::MaxBucketsDef,
	parameter int unsigned POOL_NODES = cht_pkg::PoolNodesDef,
	parameter int unsigned NAME_BYTES = cht_pkg::NameBytesDef
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire [cht_pkg::CfgW-1:0] cfg_data,
	input wire in_valid,
	output logic in_stall,
	input wire [1:0] op,
	input wire [cht_pkg::KeyW-1:0] key,
	input wire [cht_pkg::NameW-1:0] name_bytes,
	input wire [cht_pkg::YearW-1:0] year_in,
	input wire [cht_pkg::MonthW-1:0] month_in,
	input wire [cht_pkg::DayW-1:0] day_in,
	output logic out_valid,
	input wire out_stall,
	output logic [1:0] status,
	output logic [cht_pkg::NameW-1:0] name_out,
	output logic [cht_pkg::YearW-1:0] year_out,
	output logic [cht_pkg::MonthW-1:0] month_out,
	output logic [cht_pkg::DayW-1:0] day_out
);
	import cht_pkg::*;

	logic [CfgW-1:0] bcount_q;
	req_t in_req, q_req;
	logic q_valid, q_pop;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bcount_q <= CfgW'(64);
		else if (cfg_valid) bcount_q <= cfg_data;
	end

	assign in_req = '{op: op, key: key, name: name_bytes, year: year_in,
		month: month_in, day: day_in};

	cht_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	cht_back #(
		.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES), .NAME_BYTES(NAME_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .bucket_count(bcount_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.name_out(name_out), .year_out(year_out), .month_out(month_out),
		.day_out(day_out)
	);
endmodule
`default_nettype wire
